### rtl/core/idbf_pkg.sv
// Shared widths, codes and state encoding for the idle-dimming backlight fader.
// Depends on nothing; every other file of the block imports it.
package idbf_pkg;

  localparam int PCT_W     = 7;
  localparam int CFG_PCT_W = 8;
  localparam int LEN_W     = 16;
  localparam int DELAY_W   = 32;
  localparam int NOW_W     = 32;
  localparam int IDX_W     = 3;
  localparam int DATA_W    = 32;
  localparam int ROOT_W    = 10;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int PROD_W    = ROOT_W + LEN_W;
  localparam int STEP_W    = $clog2(ROOT_W);
  localparam int unsigned SCALE = 10000;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_WAKE   = 2'd1,
    OP_START  = 2'd2,
    OP_RECONF = 2'd3
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_FULL_PCT   = 3'd0,
    REG_DIM_PCT    = 3'd1,
    REG_DIM_DELAY  = 3'd2,
    REG_FADE_UP    = 3'd3,
    REG_FADE_DOWN  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_ROOT,
    S_MUL,
    S_DIV,
    S_SQR,
    S_SCALE,
    S_EMIT
  } state_t;

endpackage

### rtl/core/idbf_if.sv
// Handshake channels of the fader: operation requests in, levels out, register writes.
// Depends on idbf_pkg for the field widths.
interface idbf_in_if import idbf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, operation, now_ms, input ready);
  modport sink   (input valid, operation, now_ms, output ready);
endinterface

interface idbf_out_if import idbf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] level;
  logic             dimmed;
  logic             fading;

  modport source (output valid, level, dimmed, fading, input ready);
  modport sink   (input valid, level, dimmed, fading, output ready);
endinterface

interface idbf_cfg_if import idbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  idx;
  logic [DATA_W-1:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

### rtl/core/idle_dim_backlight_fader_unit.sv
// Idle-dimming backlight fader: command decoding, brightness state and fade sequencing.
// Depends on idbf_pkg, the channel interfaces, idbf_isqrt, idbf_sermul and idbf_serdiv.
//
// The block takes one request at a time. Wake, start, reconfigure and any update that
// computes no fade position pass from the decide state to the emit state and the output
// register. An update that computes a fade position, along a running fade or as the first
// step of dimming, first runs two square roots side by side, then uses the shared
// multiplier and the shared divider twice each, every pass being ten one-bit or two-bit
// steps. A finished result waits in the output register while the next request is
// accepted. Register writes, taken in any cycle, act on every request decided later.
module idle_dim_backlight_fader_unit import idbf_pkg::*; #(
  parameter int PERCENT_MAX = 100,
  parameter int TIME_BITS   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  idbf_in_if.sink    in_ch,
  idbf_out_if.source out_ch,
  idbf_cfg_if.sink   cfg_ch
);

  state_t state_r, state_nxt;
  logic   kick_r, kick_nxt;

  logic [CFG_PCT_W-1:0] full_pct_r, dim_pct_r;
  logic [DELAY_W-1:0]   dim_delay_r;
  logic [LEN_W-1:0]     fade_up_r, fade_down_r;

  logic [PCT_W-1:0]     level_r, level_nxt;
  logic                 dimmed_r, dimmed_nxt;
  logic [LEN_W-1:0]     flen_r, flen_nxt;
  logic [PCT_W-1:0]     from_r, from_nxt;
  logic [PCT_W-1:0]     to_r, to_nxt;
  logic [TIME_BITS-1:0] fstart_r, fstart_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic [DELAY_W-1:0]   applied_r, applied_nxt;
  op_t                  op_r, op_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;

  logic                 out_valid_r;
  logic [PCT_W-1:0]     out_level_r;
  logic                 out_dimmed_r, out_fading_r;

  logic                 in_acc, cfg_acc, emit_go;
  logic [PCT_W-1:0]     full_c, dim_raw_c, dim_c, target_c;
  logic [TIME_BITS-1:0] gone_c, idle_c;
  logic                 gone_done_c, idle_due_c, delay_changed_c;

  logic                 root_start, mul_start, div_start;
  logic                 root_a_done, root_b_done, mul_done, div_done;
  logic [ROOT_W-1:0]    root_a, root_b, quo;
  logic [PROD_W-1:0]    prod;
  logic [RAD_W-1:0]     rad_a, rad_b;
  logic                 neg_c;
  logic [ROOT_W-1:0]    span_c, at_c, mplier_c;
  logic [LEN_W-1:0]     mcand_c, divisor_c;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic [CFG_PCT_W-1:0] p);
    return (p > CFG_PCT_W'(PERCENT_MAX)) ? PCT_W'(PERCENT_MAX) : p[PCT_W-1:0];
  endfunction

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign emit_go = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign full_c    = clamp_pct(full_pct_r);
  assign dim_raw_c = clamp_pct(dim_pct_r);
  assign dim_c     = (dim_raw_c < full_c) ? dim_raw_c : full_c;

  assign gone_c          = now_r - fstart_r;
  assign idle_c          = now_r - last_r;
  assign gone_done_c     = gone_c >= TIME_BITS'(flen_r);
  assign idle_due_c      = DELAY_W'(idle_c) >= applied_r;
  assign delay_changed_c = dim_delay_r != applied_r;
  assign target_c        = dim_c;

  // Perceptual endpoints, the signed step and the position along the fade.
  assign rad_a    = RAD_W'(from_r) * RAD_W'(SCALE);
  assign rad_b    = RAD_W'(to_r) * RAD_W'(SCALE);
  assign neg_c    = root_b < root_a;
  assign span_c   = neg_c ? (root_a - root_b) : (root_b - root_a);
  assign at_c     = neg_c ? (root_a - quo) : (root_a + quo);
  assign mplier_c = (state_r == S_MUL) ? span_c : at_c;
  assign mcand_c  = (state_r == S_MUL) ? gone_c[LEN_W-1:0] : LEN_W'(at_c);
  assign divisor_c = (state_r == S_DIV) ? flen_r : LEN_W'(SCALE);

  assign root_start = kick_r && (state_r == S_ROOT);
  assign mul_start  = kick_r && ((state_r == S_MUL) || (state_r == S_SQR));
  assign div_start  = kick_r && ((state_r == S_DIV) || (state_r == S_SCALE));

  idbf_isqrt u_root_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (rad_a),
    .done     (root_a_done),
    .root     (root_a)
  );

  idbf_isqrt u_root_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (rad_b),
    .done     (root_b_done),
    .root     (root_b)
  );

  idbf_sermul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mplier  (mplier_c),
    .mcand   (mcand_c),
    .done    (mul_done),
    .product (prod)
  );

  idbf_serdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod),
    .divisor  (divisor_c),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    level_nxt   = level_r;
    dimmed_nxt  = dimmed_r;
    flen_nxt    = flen_r;
    from_nxt    = from_r;
    to_nxt      = to_r;
    fstart_nxt  = fstart_r;
    last_nxt    = last_r;
    applied_nxt = applied_r;
    op_nxt      = op_r;
    now_nxt     = now_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = op_t'(in_ch.operation);
          now_nxt   = in_ch.now_ms[TIME_BITS-1:0];
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_EMIT;
        unique case (op_r)
          OP_UPDATE: begin
            if (flen_r != '0) begin
              if (gone_done_c) begin
                level_nxt = to_r;
                flen_nxt  = '0;
              end else begin
                state_nxt = S_ROOT;
              end
            end else if (!dimmed_r && (applied_r != '0) && idle_due_c) begin
              dimmed_nxt = 1'b1;
              if ((fade_down_r == '0) || (target_c == level_r)) begin
                level_nxt = target_c;
                flen_nxt  = '0;
              end else begin
                from_nxt   = level_r;
                to_nxt     = target_c;
                flen_nxt   = fade_down_r;
                fstart_nxt = now_r;
                state_nxt  = S_ROOT;
              end
            end
          end
          OP_WAKE: begin
            last_nxt = now_r;
            if (dimmed_r) begin
              dimmed_nxt = 1'b0;
              level_nxt  = full_c;
              flen_nxt   = '0;
            end
          end
          OP_START: begin
            applied_nxt = dim_delay_r;
            dimmed_nxt  = 1'b0;
            last_nxt    = now_r;
            fstart_nxt  = now_r;
            if ((fade_up_r == '0) || (full_c == '0)) begin
              level_nxt = full_c;
              flen_nxt  = '0;
              from_nxt  = '0;
              to_nxt    = '0;
            end else begin
              level_nxt = '0;
              from_nxt  = '0;
              to_nxt    = full_c;
              flen_nxt  = fade_up_r;
            end
          end
          OP_RECONF: begin
            applied_nxt = dim_delay_r;
            flen_nxt    = '0;
            if (delay_changed_c) begin
              dimmed_nxt = 1'b0;
              last_nxt   = now_r;
              level_nxt  = full_c;
            end else begin
              level_nxt = dimmed_r ? dim_c : full_c;
            end
          end
        endcase
      end
      S_ROOT: begin
        if (root_a_done && root_b_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        if (mul_done) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (div_done) begin
          level_nxt = (quo > ROOT_W'(PERCENT_MAX)) ? PCT_W'(PERCENT_MAX) : quo[PCT_W-1:0];
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    kick_nxt = (state_nxt != state_r) &&
               (state_nxt inside {S_ROOT, S_MUL, S_DIV, S_SQR, S_SCALE});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kick_r    <= 1'b0;
      level_r   <= '0;
      dimmed_r  <= 1'b0;
      flen_r    <= '0;
      from_r    <= '0;
      to_r      <= '0;
      fstart_r  <= '0;
      last_r    <= '0;
      applied_r <= '0;
    end else begin
      kick_r    <= kick_nxt;
      level_r   <= level_nxt;
      dimmed_r  <= dimmed_nxt;
      flen_r    <= flen_nxt;
      from_r    <= from_nxt;
      to_r      <= to_nxt;
      fstart_r  <= fstart_nxt;
      last_r    <= last_nxt;
      applied_r <= applied_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    now_r <= now_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_pct_r  <= CFG_PCT_W'(100);
      dim_pct_r   <= CFG_PCT_W'(20);
      dim_delay_r <= '0;
      fade_up_r   <= LEN_W'(400);
      fade_down_r <= LEN_W'(400);
    end else if (cfg_acc) begin
      unique case (cfg_reg_t'(cfg_ch.idx))
        REG_FULL_PCT:  full_pct_r  <= cfg_ch.wdata[CFG_PCT_W-1:0];
        REG_DIM_PCT:   dim_pct_r   <= cfg_ch.wdata[CFG_PCT_W-1:0];
        REG_DIM_DELAY: dim_delay_r <= cfg_ch.wdata[DELAY_W-1:0];
        REG_FADE_UP:   fade_up_r   <= cfg_ch.wdata[LEN_W-1:0];
        REG_FADE_DOWN: fade_down_r <= cfg_ch.wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_EMIT) && emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EMIT) && emit_go) begin
      out_level_r  <= level_r;
      out_dimmed_r <= dimmed_r;
      out_fading_r <= flen_r != '0;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.level  = out_level_r;
  assign out_ch.dimmed = out_dimmed_r;
  assign out_ch.fading = out_fading_r;

endmodule

### rtl/core/idbf_isqrt.sv
// Digit-serial integer square root: two radicand bits in, one root bit out per cycle.
// Depends on idbf_pkg for the radicand and root widths.
module idbf_isqrt import idbf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic              ge;

  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = STEP_W'(ROOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      root_nxt = {root_r[ROOT_W-2:0], ge};
      if (ge) begin
        rem_nxt = rem_sh[ROOT_W:0] - trial[ROOT_W:0];
      end else begin
        rem_nxt = rem_sh[ROOT_W:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/core/idbf_sermul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on idbf_pkg for the operand and product widths.
module idbf_sermul import idbf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ROOT_W-1:0] mplier,
  input  logic [LEN_W-1:0]  mcand,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  logic [ROOT_W-1:0] a_r, a_nxt;
  logic [PROD_W-1:0] b_r, b_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = mplier;
      b_nxt    = PROD_W'(mcand);
      acc_nxt  = '0;
      cnt_nxt  = STEP_W'(ROOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (a_r[0]) begin
        acc_nxt = acc_r + b_r;
      end
      a_nxt   = a_r >> 1;
      b_nxt   = b_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

### rtl/core/idbf_serdiv.sv
// Bit-serial restoring divider yielding a short quotient, one quotient bit per cycle.
// The dividend must be below the divisor times two to the quotient width.
// Depends on idbf_pkg for the widths.
module idbf_serdiv import idbf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [LEN_W-1:0]  divisor,
  output logic              done,
  output logic [ROOT_W-1:0] quotient
);

  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] den_r, den_nxt;
  logic [ROOT_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;

  assign ge = rem_r >= den_r;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      den_nxt  = PROD_W'(divisor) << (ROOT_W - 1);
      quo_nxt  = '0;
      cnt_nxt  = STEP_W'(ROOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - den_r;
      end
      quo_nxt = {quo_r[ROOT_W-2:0], ge};
      den_nxt = den_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/idbf_chk.sv
// Port-level checks of the fader's request and result channels, bound to the top level.
// Depends on idbf_pkg and idle_dim_backlight_fader_unit.
module idbf_chk import idbf_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PCT_W-1:0] out_level,
  input logic             out_dimmed,
  input logic             out_fading
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    case ({in_acc, out_acc})
      2'b10:   pend_nxt = pend_r + 2'd1;
      2'b01:   pend_nxt = pend_r - 2'd1;
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("Request accepted while another was still being worked on.");

  a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("Result offered with no request outstanding.");

  a_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd2) |-> !in_ready)
    else $error("A third request was offered room before a result was taken.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_level) &&
                                   $stable(out_dimmed) && $stable(out_fading)))
    else $error("Stalled result changed or was withdrawn.");

endmodule

bind idle_dim_backlight_fader_unit idbf_chk u_idbf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_level  (out_ch.level),
  .out_dimmed (out_ch.dimmed),
  .out_fading (out_ch.fading)
);

### tb/idle_dim_backlight_fader_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for idle_dim_backlight_fader_unit: directed and random requests,
// with register settings changed between phases and a scoreboard predicting each level.
// Depends on idbf_pkg, the idbf channel interfaces and the block itself.
module idle_dim_backlight_fader_unit_tb;
  import idbf_pkg::*;

  typedef struct packed {
    logic [PCT_W-1:0] level;
    logic             dimmed;
    logic             fading;
  } fader_result_t;

  class fader_scoreboard;
    logic [CFG_PCT_W-1:0] full_pct, dim_pct;
    logic [DELAY_W-1:0]   dim_delay;
    logic [LEN_W-1:0]     up_len, down_len;

    logic [PCT_W-1:0]     level_now, fade_from, fade_to;
    logic                 dimmed_now;
    logic [LEN_W-1:0]     fade_len;
    logic [NOW_W-1:0]     fade_start, last_touch, delay_in_use;

    fader_result_t        due_levels[$];
    int                   errors;

    function void clear();
      full_pct     = 100;
      dim_pct      = 20;
      dim_delay    = 0;
      up_len       = 400;
      down_len     = 400;
      level_now    = 0;
      fade_from    = 0;
      fade_to      = 0;
      dimmed_now   = 0;
      fade_len     = 0;
      fade_start   = 0;
      last_touch   = 0;
      delay_in_use = 0;
      errors       = 0;
      due_levels.delete();
    endfunction

    function void set_register(cfg_reg_t r, logic [DATA_W-1:0] d);
      case (r)
        REG_FULL_PCT:  full_pct  = d[CFG_PCT_W-1:0];
        REG_DIM_PCT:   dim_pct   = d[CFG_PCT_W-1:0];
        REG_DIM_DELAY: dim_delay = d[DELAY_W-1:0];
        REG_FADE_UP:   up_len    = d[LEN_W-1:0];
        REG_FADE_DOWN: down_len  = d[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PCT_W-1:0] clamp_percent(logic [31:0] p);
      return (p > 32'd100) ? 7'd100 : p[PCT_W-1:0];
    endfunction

    function int root_of(int unsigned v);
      int unsigned r, t;
      r = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
        t = r | (32'd1 << b);
        if (t * t <= v) r = t;
      end
      return int'(r);
    endfunction

    function logic [PCT_W-1:0] fade_position(logic [NOW_W-1:0] now);
      logic [NOW_W-1:0] gone;
      int a, b, at;
      gone = now - fade_start;
      if (fade_len == 0 || gone >= fade_len) return fade_to;
      a  = root_of(int'(fade_from) * SCALE);
      b  = root_of(int'(fade_to) * SCALE);
      at = a + ((b - a) * int'(gone)) / int'(fade_len);
      if (at < 0) at = 0;
      return clamp_percent(at * at / SCALE);
    endfunction

    function logic [PCT_W-1:0] resting_level();
      logic [PCT_W-1:0] full, dim;
      full = clamp_percent(full_pct);
      if (!dimmed_now) return full;
      dim = clamp_percent(dim_pct);
      return (dim < full) ? dim : full;
    endfunction

    function void begin_fade(logic [PCT_W-1:0] target, logic [LEN_W-1:0] len,
                             logic [NOW_W-1:0] now);
      if (len == 0 || target == level_now) begin
        level_now = target;
        fade_len  = 0;
      end else begin
        fade_from  = level_now;
        fade_to    = target;
        fade_len   = len;
        fade_start = now;
      end
    endfunction

    function void predict_brightness(op_t op, logic [NOW_W-1:0] now);
      fader_result_t due;
      case (op)
        OP_UPDATE: begin
          if (fade_len != 0) begin
            level_now = fade_position(now);
            if (now - fade_start >= fade_len) fade_len = 0;
          end else if (!dimmed_now && delay_in_use != 0 &&
                       now - last_touch >= delay_in_use) begin
            dimmed_now = 1;
            begin_fade(resting_level(), down_len, now);
            if (fade_len != 0) level_now = fade_position(now);
          end
        end
        OP_WAKE: begin
          last_touch = now;
          if (dimmed_now) begin
            dimmed_now = 0;
            level_now  = resting_level();
            fade_len   = 0;
          end
        end
        OP_START: begin
          delay_in_use = dim_delay;
          level_now    = 0;
          dimmed_now   = 0;
          last_touch   = now;
          fade_len     = 0;
          fade_from    = 0;
          fade_to      = 0;
          fade_start   = now;
          begin_fade(clamp_percent(full_pct), up_len, now);
        end
        default: begin
          if (dim_delay != delay_in_use) begin
            dimmed_now = 0;
            last_touch = now;
          end
          delay_in_use = dim_delay;
          level_now    = resting_level();
          fade_len     = 0;
        end
      endcase
      due.level  = level_now;
      due.dimmed = dimmed_now;
      due.fading = (fade_len != 0);
      due_levels.push_back(due);
    endfunction

    task report(string what);
      errors++;
      $display("%t mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [PCT_W-1:0] level, logic dimmed, logic fading);
      fader_result_t due;
      if (due_levels.size() == 0) begin
        report($sformatf("result level %0d with no request outstanding", level));
        return;
      end
      due = due_levels.pop_front();
      if (level !== due.level)
        report($sformatf("level %0d, expected %0d", level, due.level));
      if (dimmed !== due.dimmed)
        report($sformatf("dimmed %b, expected %b", dimmed, due.dimmed));
      if (fading !== due.fading)
        report($sformatf("fading %b, expected %b", fading, due.fading));
    endtask

    function int outstanding();
      return due_levels.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   send_gaps, take_gaps;
  logic [NOW_W-1:0] clock_ms;
  fader_scoreboard sb;

  idbf_in_if  in_ch();
  idbf_out_if out_ch();
  idbf_cfg_if cfg_ch();

  idle_dim_backlight_fader_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[idle_dim_backlight_fader_unit] ERROR");
    $finish;
  end

  task automatic send_request(op_t op, logic [NOW_W-1:0] now);
    int gap;
    gap = send_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.now_ms    <= now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.predict_brightness(op, now);
  endtask

  task automatic write_register(cfg_reg_t r, logic [DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= r;
    cfg_ch.wdata <= d;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_register(r, d);
  endtask

  task automatic wait_idle();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(logic [7:0] full, logic [7:0] dim, logic [31:0] delay,
                                logic [15:0] up, logic [15:0] down);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait_idle();
    write_register(REG_FULL_PCT, DATA_W'(full));
    write_register(REG_DIM_PCT, DATA_W'(dim));
    write_register(REG_DIM_DELAY, delay);
    write_register(REG_FADE_UP, DATA_W'(up));
    write_register(REG_FADE_DOWN, DATA_W'(down));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_percent();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd100;
      2: return 8'd255;
      3: return 8'($urandom_range(101, 255));
      default: return 8'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      3: return 16'd1;
      default: return 16'($urandom_range(2, 600));
    endcase
  endfunction

  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return 32'($urandom_range(1, 600));
    endcase
  endfunction

  function automatic op_t pick_operation();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return OP_UPDATE;
    if (r < 80) return OP_WAKE;
    if (r < 88) return OP_RECONF;
    return OP_START;
  endfunction

  function automatic logic [NOW_W-1:0] advance_clock(logic [NOW_W-1:0] t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom;
    if (r < 9) return t + 32'($urandom_range(0, 70000));
    return t + 32'($urandom_range(0, 90));
  endfunction

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int gap;
      gap = take_gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.check_result(out_ch.level, out_ch.dimmed, out_ch.fading);
    end
  end

  initial begin
    sb = new();
    sb.clear();
    send_gaps        = 1'b1;
    take_gaps        = 1'b1;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_UPDATE;
    in_ch.now_ms    <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.idx      <= REG_FULL_PCT;
    cfg_ch.wdata    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Requests before any start act on the reset state; the later ones cover dimming,
    // waking, fading up across the wrap of the millisecond counter and a backward step.
    send_request(OP_UPDATE, 32'd5);
    send_request(OP_WAKE, 32'd10);
    apply_settings(8'd100, 8'd20, 32'd1000, 16'd400, 16'd400);
    send_request(OP_RECONF, 32'd20);
    send_request(OP_UPDATE, 32'd1020);
    send_request(OP_UPDATE, 32'd1220);
    send_request(OP_WAKE, 32'd1300);
    send_request(OP_WAKE, 32'd1350);
    send_request(OP_START, 32'd2000);
    send_request(OP_UPDATE, 32'd2100);
    send_request(OP_UPDATE, 32'd2400);
    send_request(OP_UPDATE, 32'd3400);
    send_request(OP_UPDATE, 32'd3900);
    send_request(OP_RECONF, 32'd4000);
    send_request(OP_START, 32'hFFFF_FF00);
    send_request(OP_UPDATE, 32'h0000_0010);
    send_request(OP_UPDATE, 32'hFFFF_FFFF);
    send_request(OP_UPDATE, 32'h0000_0200);

    // Clamped percentages, the longest delay and a zero-length start fade.
    apply_settings(8'd255, 8'd255, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
    send_request(OP_START, 32'd500);
    send_request(OP_UPDATE, 32'd499);
    send_request(OP_WAKE, 32'd600);

    apply_settings(8'd60, 8'd80, 32'd50, 16'd1, 16'd0);
    send_request(OP_START, 32'd1000);
    send_request(OP_UPDATE, 32'd1000);
    send_request(OP_UPDATE, 32'd1001);
    send_request(OP_UPDATE, 32'd1100);

    clock_ms = 32'd2000;
    for (int phase = 0; phase < 20; phase++) begin
      apply_settings(pick_percent(), pick_percent(), pick_delay(), pick_length(),
                     pick_length());
      send_gaps = (phase % 4 == 1) || (phase % 4 == 3);
      take_gaps = (phase % 4 == 2) || (phase % 4 == 3);
      if ($urandom_range(0, 3) == 0)
        clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
      if ($urandom_range(0, 4) != 0) send_request(OP_START, clock_ms);
      for (int n = 0; n < 100; n++) begin
        clock_ms = advance_clock(clock_ms);
        send_request(pick_operation(), clock_ms);
      end
    end

    in_ch.valid <= 1'b0;
    wait_idle();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[idle_dim_backlight_fader_unit] OK");
    end else begin
      $display("[idle_dim_backlight_fader_unit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/idbf_pkg.sv
rtl/core/idbf_if.sv
rtl/core/idbf_isqrt.sv
rtl/core/idbf_sermul.sv
rtl/core/idbf_serdiv.sv
rtl/core/idle_dim_backlight_fader_unit.sv
rtl/core/idbf_chk.sv
tb/idle_dim_backlight_fader_unit_tb.sv
